>>> rtl/oett_pkg.sv
// Package for the ordered expiry timer table: sizes, opcodes and payload types.
// Shared by the cell chain and the top level; depends on nothing.
`timescale 1ns / 1ps

package oett_pkg;

  localparam int TABLE_DEPTH  = 32;
  localparam int COORD_BITS   = 10;
  localparam int TYPE_BITS    = 4;
  localparam int OWNER_BITS   = 16;
  localparam int LEVEL_BITS   = 4;
  localparam int TICK_BITS    = 16;
  localparam int ELAPSED_BITS = 24;

  localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_CREATE = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [TICK_BITS-1:0]    tick_amount;
    logic [TYPE_BITS-1:0]    job_type;
    logic [COORD_BITS-1:0]   pos_x;
    logic [COORD_BITS-1:0]   pos_y;
    logic [OWNER_BITS-1:0]   owner_id;
    logic [LEVEL_BITS-1:0]   job_level;
    logic [ELAPSED_BITS-1:0] job_duration;
  } in_item_t;

  typedef struct packed {
    logic [TYPE_BITS-1:0]  done_type;
    logic [COORD_BITS-1:0] done_x;
    logic [COORD_BITS-1:0] done_y;
    logic [OWNER_BITS-1:0] done_owner;
    logic [LEVEL_BITS-1:0] done_level;
    logic                  last_expired;
  } out_item_t;

  typedef struct packed {
    logic [ELAPSED_BITS-1:0] elapsed;
    logic [ELAPSED_BITS-1:0] duration;
    logic [TYPE_BITS-1:0]    jtype;
    logic [COORD_BITS-1:0]   x;
    logic [COORD_BITS-1:0]   y;
    logic [OWNER_BITS-1:0]   owner;
    logic [LEVEL_BITS-1:0]   level;
  } job_t;

  typedef struct packed {
    logic valid;
    logic pending;   // not yet visited by the running pass
    job_t job;
  } entry_t;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    logic                 start;    // open a pass: pending <= valid
    logic                 add_en;   // with start: add amount to elapsed
    logic [TICK_BITS-1:0] amount;
    logic                 create;   // append new_job at the first free cell
    job_t                 new_job;
    logic                 shift;    // chain moves one cell towards the head
    logic                 keep;     // with shift: head job goes back in behind the rest
    job_t                 head_job;
  } cell_ctrl_t;

endpackage

>>> rtl/oett_cell.sv
// One slot of the timer chain: holds a job, shifts towards the head and
// takes appended jobs. Depends on oett_pkg.
`timescale 1ns / 1ps

module oett_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  oett_pkg::cell_ctrl_t ctrl_i,
  input  logic                prev_valid_i,
  input  oett_pkg::entry_t    next_i,
  output oett_pkg::entry_t    entry_o
);
  import oett_pkg::*;

  logic                    valid_q, valid_d;
  logic                    pend_q, pend_d;
  job_t                    job_q, job_d;
  logic [ELAPSED_BITS:0]   sum;

  assign sum = {1'b0, job_q.elapsed}
             + {{(ELAPSED_BITS + 1 - TICK_BITS){1'b0}}, ctrl_i.amount};

  always_comb begin
    valid_d = valid_q;
    pend_d  = pend_q;
    job_d   = job_q;
    if (ctrl_i.start) begin
      pend_d = valid_q;
      if (ctrl_i.add_en) begin
        job_d.elapsed = sum[ELAPSED_BITS] ? ELAPSED_MAX : sum[ELAPSED_BITS-1:0];
      end
    end else if (ctrl_i.create) begin
      if (!valid_q && prev_valid_i) begin
        valid_d = 1'b1;
        pend_d  = 1'b0;
        job_d   = ctrl_i.new_job;
      end
    end else if (ctrl_i.shift) begin
      // after the move this cell is the first free one: the kept head lands here
      if (!next_i.valid && valid_q && ctrl_i.keep) begin
        valid_d = 1'b1;
        pend_d  = 1'b0;
        job_d   = ctrl_i.head_job;
      end else begin
        valid_d = next_i.valid;
        pend_d  = next_i.pending;
        job_d   = next_i.job;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign entry_o.valid   = valid_q;
  assign entry_o.pending = pend_q;
  assign entry_o.job     = job_q;

endmodule

>>> rtl/ordered_expiry_timer_table_unit.sv
// Top level of the ordered expiry timer table: chain of oett_cell slots and
// the pass sequencer with output holding stage. Depends on oett_pkg, oett_cell.
//
//   channel  | signals                                  | direction
//   input    | in_valid_i, in_stall_o, in_item_i        | job commands in
//   output   | out_valid_o, out_stall_i, out_item_o     | expired jobs out
//
// Create and opcode three need no pass. Tick and remove run a pass over the
// stored jobs, and a tick then releases the final expired job: the pass
// opens, the chain moves one job past the head per cycle, where it is tested,
// while no output stall holds it, and the sequencer then finds the pass complete.
// Output stalls hold the pass only when an expired job must move on while the
// one before it still waits, and they delay the release of the final one.
// Reset empties the table at once; no clearing pass.
`timescale 1ns / 1ps

module ordered_expiry_timer_table_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  oett_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output oett_pkg::out_item_t  out_item_o
);
  import oett_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_PASS, ST_FLUSH} state_e;

  state_e                state_q, state_d;
  logic                  is_tick_q, is_tick_d;
  logic [TYPE_BITS-1:0]  key_type_q, key_type_d;
  logic [COORD_BITS-1:0] key_x_q, key_x_d;
  logic [COORD_BITS-1:0] key_y_q, key_y_d;
  out_item_t             hold_q, hold_d;
  logic                  hold_v_q, hold_v_d;
  out_item_t             out_q, out_d;
  logic                  out_v_q, out_v_d;

  cell_ctrl_t ctrl;
  entry_t     entries [TABLE_DEPTH];
  entry_t     head;
  logic       accept, head_exp, head_match, drop, out_free, step_ok;
  out_item_t  head_item;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign head       = entries[0];
  assign head_exp   = head.job.elapsed >= head.job.duration;
  assign head_match = (head.job.jtype == key_type_q) && (head.job.x == key_x_q)
                   && (head.job.y == key_y_q);
  assign drop       = is_tick_q ? head_exp : head_match;
  assign out_free   = !out_v_q || !out_stall_i;
  // an expiry needs room when a previous one still waits in the hold stage
  assign step_ok    = !(is_tick_q && head_exp) || !hold_v_q || out_free;

  assign head_item.done_type    = head.job.jtype;
  assign head_item.done_x       = head.job.x;
  assign head_item.done_y       = head.job.y;
  assign head_item.done_owner   = head.job.owner;
  assign head_item.done_level   = head.job.level;
  assign head_item.last_expired = 1'b0;

  always_comb begin
    ctrl                  = '0;
    ctrl.amount           = in_item_i.tick_amount;
    ctrl.new_job.elapsed  = '0;
    ctrl.new_job.duration = in_item_i.job_duration;
    ctrl.new_job.jtype    = in_item_i.job_type;
    ctrl.new_job.x        = in_item_i.pos_x;
    ctrl.new_job.y        = in_item_i.pos_y;
    ctrl.new_job.owner    = in_item_i.owner_id;
    ctrl.new_job.level    = in_item_i.job_level;
    ctrl.head_job         = head.job;
    ctrl.keep             = !drop;

    state_d    = state_q;
    is_tick_d  = is_tick_q;
    key_type_d = key_type_q;
    key_x_d    = key_x_q;
    key_y_d    = key_y_q;
    hold_d     = hold_q;
    hold_v_d   = hold_v_q;
    out_d      = out_q;
    out_v_d    = out_v_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          is_tick_d  = (in_item_i.opcode == OP_TICK);
          key_type_d = in_item_i.job_type;
          key_x_d    = in_item_i.pos_x;
          key_y_d    = in_item_i.pos_y;
          if (in_item_i.opcode == OP_TICK || in_item_i.opcode == OP_REMOVE) begin
            ctrl.start  = 1'b1;
            ctrl.add_en = (in_item_i.opcode == OP_TICK);
            state_d     = ST_PASS;
          end else if (in_item_i.opcode == OP_CREATE) begin
            ctrl.create = 1'b1;
          end
        end
      end
      ST_PASS: begin
        if (head.pending) begin
          if (step_ok) begin
            ctrl.shift = 1'b1;
            if (is_tick_q && head_exp) begin
              if (hold_v_q) begin
                out_d   = hold_q;
                out_v_d = 1'b1;
              end
              hold_d   = head_item;
              hold_v_d = 1'b1;
            end
          end
        end else begin
          state_d = hold_v_q ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_d              = hold_q;
          out_d.last_expired = 1'b1;
          out_v_d            = 1'b1;
          hold_v_d           = 1'b0;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      is_tick_q  <= 1'b0;
      key_type_q <= '0;
      key_x_q    <= '0;
      key_y_q    <= '0;
      hold_q     <= '0;
      hold_v_q   <= 1'b0;
      out_q      <= '0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      is_tick_q  <= is_tick_d;
      key_type_q <= key_type_d;
      key_x_q    <= key_x_d;
      key_y_q    <= key_y_d;
      hold_q     <= hold_d;
      hold_v_q   <= hold_v_d;
      out_q      <= out_d;
      out_v_q    <= out_v_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic   prev_valid;
    entry_t next_entry;
    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = entries[i-1].valid;
    end
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_link
      assign next_entry = entries[i+1];
    end
    oett_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_valid_i (prev_valid),
      .next_i       (next_entry),
      .entry_o      (entries[i])
    );
  end

endmodule
